[design/chm_pkg.sv]
package chm_pkg;
  localparam int MAX_BUCKETS = 64;
  localparam int POOL_NODES = 256;
  localparam int BW = $clog2(MAX_BUCKETS);
  localparam int NW = $clog2(POOL_NODES);
  localparam int PW = NW + 1;
  localparam logic [PW-1:0] NIL = PW'(POOL_NODES);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_FIND = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] handle;
  } result_t;
endpackage

[design/chm_mod.sv]
module chm_mod (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [31:0] key,
  input  logic [6:0] cnt,
  output logic busy,
  output logic [chm_pkg::BW-1:0] bucket
);
  import chm_pkg::*;
  // Restoring remainder, one bit of the key per cycle.
  logic [31:0] sh;
  logic [7:0] rem;
  logic [6:0] d;
  logic [5:0] n;
  logic [7:0] t;
  always_comb begin
    t = {rem[6:0], sh[31]};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      sh <= key;
      rem <= '0;
      n <= '0;
      if (cnt == 7'd0) d <= 7'd1;
      else if (cnt > 7'(MAX_BUCKETS)) d <= 7'(MAX_BUCKETS);
      else d <= cnt;
    end else if (busy) begin
      sh <= {sh[30:0], 1'b0};
      rem <= (t >= {1'b0, d}) ? t - {1'b0, d} : t;
      n <= n + 6'd1;
      if (n == 6'd31) busy <= 1'b0;
    end
  end
  assign bucket = BW'(rem);
endmodule

[design/chained_hash_map.sv]
// Flow: the hash shifts in one key bit per cycle after the start; an insert then
// passes S_HEAD, S_FREE and S_DONE; a find or remove that visits n chain nodes
// passes S_HEAD, then S_READ (memory read) and S_CMP (compare) per node.
// One item at a time; the next item is taken in the cycle after the result is
// loaded.
// Reset (rst, synchronous): bucket heads cleared through valid bits, free
// stack served as identity below a low-water mark, bucket_count set to 64.
// No clearing pass is needed.
module chained_hash_map (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [71:0] s_tdata, // cmd[1:0], key[33:2], handle_in[65:34], zeros
  output logic m_tvalid,
  input  logic m_tready,
  output logic [39:0] m_tdata, // status[1:0], handle_out[33:2], zeros
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [6:0] cfg_data
);
  import chm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_HASH = 3'd1, S_HEAD = 3'd2,
    S_READ = 3'd3, S_CMP = 3'd4, S_FREE = 3'd5, S_DONE = 3'd6;

  logic [2:0] state;
  logic [6:0] bucket_count;
  logic [1:0] cmd;
  logic [31:0] key, hin;
  logic hstart, hbusy;
  logic [BW-1:0] bucket;

  // Bucket heads in a memory with valid bits; node pool in memories.
  logic [PW-1:0] head [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] head_v;
  logic [31:0] nkey [POOL_NODES];
  logic [31:0] nhdl [POOL_NODES];
  logic [PW-1:0] nnext [POOL_NODES];
  logic [NW-1:0] fstack [POOL_NODES];
  // The free count has never dropped below the fill mark, so entries below the
  // mark have never been written and read as their own index.
  logic [PW-1:0] fmark, fcount;

  logic [31:0] rkey, rhdl;
  logic [PW-1:0] rnext;
  logic [PW-1:0] rhead;
  logic [NW-1:0] rfree;
  logic [PW-1:0] cur, prev;
  logic [8:0] steps;
  result_t res;
  result_t obuf;
  logic [NW-1:0] ridx;
  logic [NW-1:0] nfree;

  chm_mod u_mod (.clk, .rst, .start(hstart), .key(s_tdata[33:2]), .cnt(bucket_count),
    .busy(hbusy), .bucket);

  // The result register lets a new item in while the previous result waits.
  assign s_tready = (state == S_IDLE);
  assign hstart = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tdata = {6'd0, obuf.handle, obuf.status};
  assign ridx = fcount[NW-1:0] - NW'(1);
  assign nfree = (PW'(ridx) < fmark) ? ridx : rfree;

  logic [PW-1:0] hd;
  assign hd = head_v[bucket] ? rhead : NIL;

  always_ff @(posedge clk) begin
    rkey <= nkey[cur[NW-1:0]];
    rhdl <= nhdl[cur[NW-1:0]];
    rnext <= nnext[cur[NW-1:0]];
    rfree <= fstack[ridx];
    rhead <= head[bucket];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      head_v <= '0;
      fcount <= PW'(POOL_NODES);
      fmark <= PW'(POOL_NODES);
      bucket_count <= 7'(MAX_BUCKETS);
    end else begin
      if (cfg_valid) bucket_count <= cfg_data;
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        obuf <= res;
        m_tvalid <= 1'b1;
      end else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (hstart) begin
          cmd <= s_tdata[1:0];
          key <= s_tdata[33:2];
          hin <= s_tdata[65:34];
          state <= S_HASH;
        end
        S_HASH: if (!hbusy && !hstart) state <= S_HEAD;
        S_HEAD: begin
          // rhead and rfree were read for this bucket and ridx in the last cycle.
          res.handle <= 32'd0;
          res.status <= (cmd == CMD_INSERT && fcount == '0) ? ST_FULL : ST_MISS;
          cur <= hd;
          prev <= NIL;
          steps <= '0;
          if (cmd == CMD_INSERT) begin
            if (fcount == '0) state <= S_DONE;
            else state <= S_FREE;
          end else if (cmd == CMD_FIND || cmd == CMD_REMOVE) begin
            state <= (hd == NIL) ? S_DONE : S_READ;
          end else state <= S_DONE;
        end
        S_FREE: begin
          nkey[nfree] <= key;
          nhdl[nfree] <= hin;
          nnext[nfree] <= hd;
          head[bucket] <= PW'(nfree);
          head_v[bucket] <= 1'b1;
          fcount <= fcount - PW'(1);
          if (PW'(ridx) < fmark) fmark <= PW'(ridx);
          res.status <= ST_OK;
          state <= S_DONE;
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (rkey == key) begin
            res.status <= ST_OK;
            if (cmd == CMD_FIND) res.handle <= rhdl;
            else begin
              if (prev != NIL) nnext[prev[NW-1:0]] <= rnext;
              else begin
                head[bucket] <= rnext;
                head_v[bucket] <= 1'b1;
              end
              fstack[fcount[NW-1:0]] <= cur[NW-1:0];
              fcount <= fcount + PW'(1);
            end
            state <= S_DONE;
          end else begin
            prev <= cur;
            cur <= rnext;
            steps <= steps + 9'd1;
            state <= (rnext == NIL || steps == 9'(POOL_NODES - 1)) ? S_DONE : S_READ;
          end
        end
        S_DONE: if (!m_tvalid || m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[design/chm_check.sv]
module chm_check (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [39:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("second item taken while busy");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3) else $error("bad status");
  a_hz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != 2'd0 |-> m_tdata[33:2] == 32'd0) else $error("nonzero handle");
endmodule

bind chained_hash_map chm_check u_chk (.clk, .rst, .s_tvalid, .s_tready, .m_tvalid,
  .m_tready, .m_tdata);
